// ----- hw/rtl/json_string_unescaper_top_macros.svh -----
// Assertion macros shared by the JSON string unescaper RTL.
// Bodies expand to concurrent assertions unless SYNTH is defined.
`ifndef JSON_STRING_UNESCAPER_TOP_MACROS_SVH
`define JSON_STRING_UNESCAPER_TOP_MACROS_SVH
`ifndef SYNTH
`define JSU_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");
`define JSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define JSU_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define JSU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- hw/rtl/jsu_pkg.sv -----
// Types and constants for the JSON string unescaper.
// No dependencies; used by jsu_decode and json_string_unescaper_top.
package jsu_pkg;

  typedef enum logic [1:0] {
    MODE_NORMAL,
    MODE_ESCAPE,
    MODE_HEX,
    MODE_DRAIN
  } mode_e;

  localparam int unsigned GroupMax = 4;

  localparam logic [7:0] CharBackslash = 8'h5C;
  localparam logic [7:0] CharQuote     = 8'h22;
  localparam logic [7:0] CharSlash     = 8'h2F;
  localparam logic [7:0] CharB         = 8'h62;
  localparam logic [7:0] CharF         = 8'h66;
  localparam logic [7:0] CharN         = 8'h6E;
  localparam logic [7:0] CharR         = 8'h72;
  localparam logic [7:0] CharT         = 8'h74;
  localparam logic [7:0] CharLowerU    = 8'h75;
  localparam logic [7:0] CharUpperU    = 8'h55;

  localparam logic [7:0] Utf8Lead2 = 8'hC0;
  localparam logic [7:0] Utf8Lead3 = 8'hE0;
  localparam logic [7:0] Utf8Lead4 = 8'hF0;
  localparam logic [7:0] Utf8Cont  = 8'h80;

  // All results caused by one input byte; cnt_m1 is the result count minus one.
  typedef struct packed {
    logic [GroupMax-1:0][7:0] bytes;
    logic [1:0]               cnt_m1;
    logic                     has_byte;
    logic                     error;
    logic                     last;
  } group_t;

endpackage

// ----- hw/rtl/jsu_decode.sv -----
// Escape decoder state and per-byte result group computation.
// Depends on jsu_pkg.
module jsu_decode (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      in_byte_i,
  input  logic            in_last_i,
  output logic            push_o,
  output jsu_pkg::group_t group_o
);

  jsu_pkg::mode_e mode_q, mode_d;
  logic [3:0]     left_q, left_d;
  logic [31:0]    acc_q, acc_d;

  logic [31:0]    acc_new;
  logic [3:0]     left_dec;
  logic [2:0]     n;
  logic [3:0][7:0] bytes;
  logic           err;
  logic           bad_end;
  logic           hex_ok;
  logic [3:0]     hex_val;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (in_byte_i >= 8'h30 && in_byte_i <= 8'h39) begin
      hex_val = 4'(in_byte_i - 8'h30);
    end else if (in_byte_i >= 8'h61 && in_byte_i <= 8'h66) begin
      hex_val = 4'(in_byte_i - 8'h57);
    end else if (in_byte_i >= 8'h41 && in_byte_i <= 8'h46) begin
      hex_val = 4'(in_byte_i - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign acc_new  = {acc_q[27:0], hex_val};
  assign left_dec = left_q - 4'd1;

  always_comb begin
    mode_d = mode_q;
    left_d = left_q;
    acc_d  = acc_q;
    n      = 3'd0;
    bytes  = '0;
    err    = 1'b0;
    case (mode_q)
      jsu_pkg::MODE_NORMAL: begin
        if (in_byte_i == jsu_pkg::CharBackslash) begin
          mode_d = jsu_pkg::MODE_ESCAPE;
        end else begin
          n        = 3'd1;
          bytes[0] = in_byte_i;
        end
      end
      jsu_pkg::MODE_ESCAPE: begin
        mode_d = jsu_pkg::MODE_NORMAL;
        n      = 3'd1;
        case (in_byte_i)
          jsu_pkg::CharQuote, jsu_pkg::CharBackslash, jsu_pkg::CharSlash: bytes[0] = in_byte_i;
          jsu_pkg::CharB: bytes[0] = 8'h08;
          jsu_pkg::CharF: bytes[0] = 8'h0C;
          jsu_pkg::CharN: bytes[0] = 8'h0A;
          jsu_pkg::CharR: bytes[0] = 8'h0D;
          jsu_pkg::CharT: bytes[0] = 8'h09;
          jsu_pkg::CharLowerU: begin
            n      = 3'd0;
            mode_d = jsu_pkg::MODE_HEX;
            left_d = 4'd4;
            acc_d  = '0;
          end
          jsu_pkg::CharUpperU: begin
            n      = 3'd0;
            mode_d = jsu_pkg::MODE_HEX;
            left_d = 4'd8;
            acc_d  = '0;
          end
          default: begin
            n   = 3'd0;
            err = 1'b1;
          end
        endcase
      end
      jsu_pkg::MODE_HEX: begin
        if (!hex_ok) begin
          err = 1'b1;
        end else begin
          left_d = left_dec;
          acc_d  = acc_new;
          if (left_dec == 4'd0) begin
            mode_d = jsu_pkg::MODE_NORMAL;
            acc_d  = '0;
            if (acc_new[31:8] == '0) begin
              n        = 3'd1;
              bytes[0] = acc_new[7:0];
            end else if (acc_new[31:11] == '0) begin
              n        = 3'd2;
              bytes[0] = jsu_pkg::Utf8Lead2 | {3'b000, acc_new[10:6]};
              bytes[1] = jsu_pkg::Utf8Cont | {2'b00, acc_new[5:0]};
            end else if (acc_new[31:16] == '0) begin
              n        = 3'd3;
              bytes[0] = jsu_pkg::Utf8Lead3 | {4'b0000, acc_new[15:12]};
              bytes[1] = jsu_pkg::Utf8Cont | {2'b00, acc_new[11:6]};
              bytes[2] = jsu_pkg::Utf8Cont | {2'b00, acc_new[5:0]};
            end else begin
              n        = 3'd4;
              bytes[0] = jsu_pkg::Utf8Lead4 | {5'b00000, acc_new[20:18]};
              bytes[1] = jsu_pkg::Utf8Cont | {2'b00, acc_new[17:12]};
              bytes[2] = jsu_pkg::Utf8Cont | {2'b00, acc_new[11:6]};
              bytes[3] = jsu_pkg::Utf8Cont | {2'b00, acc_new[5:0]};
            end
          end
        end
      end
      default: begin
      end
    endcase
    if (err) begin
      mode_d = jsu_pkg::MODE_DRAIN;
    end
    if (in_last_i) begin
      mode_d = jsu_pkg::MODE_NORMAL;
      left_d = '0;
      acc_d  = '0;
    end
  end

  // A string that closes inside an escape body or after an error ends in an error marker.
  assign bad_end = err || mode_q == jsu_pkg::MODE_DRAIN ||
                   (mode_q == jsu_pkg::MODE_HEX && !(hex_ok && left_dec == 4'd0)) ||
                   (mode_q == jsu_pkg::MODE_ESCAPE &&
                    (in_byte_i == jsu_pkg::CharLowerU || in_byte_i == jsu_pkg::CharUpperU));

  assign push_o = accept_i && (in_last_i || n != 3'd0);

  always_comb begin
    group_o.bytes    = bytes;
    group_o.cnt_m1   = 2'(n - 3'd1);
    group_o.has_byte = 1'b1;
    group_o.error    = 1'b0;
    group_o.last     = in_last_i;
    if (in_last_i && (bad_end || n == 3'd0)) begin
      group_o.bytes    = '0;
      group_o.cnt_m1   = 2'd0;
      group_o.has_byte = 1'b0;
      group_o.error    = bad_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= jsu_pkg::MODE_NORMAL;
      left_q <= '0;
      acc_q  <= '0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      left_q <= left_d;
      acc_q  <= acc_d;
    end
  end

endmodule

// ----- hw/rtl/json_string_unescaper_top.sv -----
// Top level of the JSON string unescaper: decoder plus a two-entry result group queue.
// Depends on jsu_pkg, jsu_decode and json_string_unescaper_top_macros.svh.
//
//   channel | handshake            | payload
//   input   | in_valid_i/in_stall_o | in_byte_i, in_last_i
//   output  | out_valid_o/out_stall_i | out_byte_o, has_byte_o, error_o, out_last_o
//
// One input byte is taken per cycle while in_stall_o is low; its result group is registered into the queue.
// A byte that decodes to several UTF-8 bytes is sent on the output port one byte at a time.
// The queue holds two result groups, so input is stalled only when both are occupied.
// Reset returns the decoder to normal byte mode and empties the queue.
`include "json_string_unescaper_top_macros.svh"
module json_string_unescaper_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       has_byte_o,
  output logic       error_o,
  output logic       out_last_o
);

  logic            accept;
  logic            push;
  logic            pop;
  logic            head_end;
  jsu_pkg::group_t group_new;
  jsu_pkg::group_t grp_q [2];
  jsu_pkg::group_t head;
  logic [1:0]      cnt_q, cnt_d;
  logic            rd_q;
  logic            wr_q;
  logic [1:0]      idx_q;

  assign in_stall_o = cnt_q == 2'd2;
  assign accept     = in_valid_i && !in_stall_o;

  jsu_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_byte_i (in_byte_i),
    .in_last_i (in_last_i),
    .push_o    (push),
    .group_o   (group_new)
  );

  assign head        = grp_q[rd_q];
  assign head_end    = idx_q == head.cnt_m1;
  assign out_valid_o = cnt_q != 2'd0;
  assign out_byte_o  = head.bytes[idx_q];
  assign has_byte_o  = head.has_byte;
  assign error_o     = head.error;
  assign out_last_o  = head.last && head_end;
  assign pop         = out_valid_o && !out_stall_i && head_end;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      grp_q[wr_q] <= group_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
      idx_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_q <= !wr_q;
      end
      if (pop) begin
        rd_q  <= !rd_q;
        idx_q <= '0;
      end else if (out_valid_o && !out_stall_i) begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  `JSU_ASSERT_IMPLIES(a_cnt_range, clk_i, rst_ni, 1'b1, cnt_q != 2'd3)
  `JSU_ASSERT_IMPLIES(a_err_marker, clk_i, rst_ni, out_valid_o && error_o, out_last_o && !has_byte_o)
  `JSU_ASSERT_IMPLIES(a_bare_last, clk_i, rst_ni, out_valid_o && !has_byte_o, out_last_o && idx_q == 2'd0)
  `JSU_ASSERT_NEXT(a_pop_only, clk_i, rst_ni, pop && !push, cnt_q == $past(cnt_q) - 2'd1)

endmodule
